@@ rtl/fqrm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqrm_pkg
// Shared types and codes for the queue with remove-all-matching.
// ----------------------------------------------------------------------------
package fqrm_pkg;

  localparam int DataW = 32;
  localparam int FieldW = 5;  // width of removed_count and occupancy

  typedef enum logic [1:0] {
    ACT_ENQ    = 2'd0,
    ACT_DEQ    = 2'd1,
    ACT_PEEK   = 2'd2,
    ACT_REMOVE = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CMD_HOLD   = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_SHIFT  = 2'd2
  } cell_op_e;

  // Broadcast to every cell of the chain in each cycle.
  typedef struct packed {
    cell_op_e          op;
    logic              keep;   // shift: head re-enters at the tail
    logic [DataW-1:0]  wdata;  // append word, or the head on a shift
  } cell_cmd_t;

endpackage

@@ rtl/fqrm_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqrm_in_if
// Request channel: action and value with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface fqrm_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic signed [31:0] value;

  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);
endinterface

@@ rtl/fqrm_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqrm_out_if
// Response channel: one result per request with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface fqrm_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] data_out;
  logic [4:0]         removed_count;
  logic [4:0]         occupancy;
  logic               is_empty;
  logic [1:0]         status;

  modport source (output valid, output data_out, output removed_count,
                  output occupancy, output is_empty, output status, input ready);
  modport sink   (input valid, input data_out, input removed_count,
                  input occupancy, input is_empty, input status, output ready);
endinterface

@@ rtl/fifo_queue_remove_matching_core.sv @@
`timescale 1ns / 1ps
// Timing: enqueue, dequeue and peek finish in the accept cycle; the result
//   is registered and valid the next cycle. A remove rotates the chain once
//   per held entry, dropping matches, before the result loads.
// Throughput: one transaction per cycle for enqueue/dequeue/peek while the
//   output is not stalled; no new request is accepted during a remove walk.
// Reset: rst_ni clears the count, FSM and output valid; slot data is not reset.
// ----------------------------------------------------------------------------
// fifo_queue_remove_matching_core
// Bounded FIFO of signed words built as a chain of shifting cells, with a
// remove-all-matching action that compacts the queue in order.
// ----------------------------------------------------------------------------
module fifo_queue_remove_matching_core #(
  parameter int DEPTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  fqrm_in_if.sink           in_i,
  fqrm_out_if.source        out_o
);

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int IW   = $clog2(DEPTH);
  localparam int ExtW = (CW > fqrm_pkg::FieldW) ? CW : fqrm_pkg::FieldW;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_REMOVE = 2'b10
  } state_e;

  state_e                     st_q, st_d;
  logic [CW-1:0]              count_q, count_d;
  logic [CW-1:0]              remain_q, remain_d;
  logic [CW-1:0]              removed_q, removed_d;
  logic [fqrm_pkg::DataW-1:0] key_q, key_d;

  logic                       out_valid_q, out_valid_d;
  logic [fqrm_pkg::DataW-1:0] res_data_q, res_data_d;
  logic [fqrm_pkg::FieldW-1:0] res_removed_q, res_removed_d;
  logic [fqrm_pkg::FieldW-1:0] res_occ_q, res_occ_d;
  logic                       res_empty_q, res_empty_d;
  fqrm_pkg::status_e          res_status_q, res_status_d;

  fqrm_pkg::cell_cmd_t        cmd;
  logic [IW-1:0]              tail;
  logic [fqrm_pkg::DataW-1:0] cell_data [DEPTH];
  logic [fqrm_pkg::DataW-1:0] head;

  logic                       out_free, in_fire, is_full, is_empty, match;
  logic                       res_load;
  logic [CW-1:0]              res_removed_cnt;
  logic [ExtW-1:0]            occ_ext, rem_ext;

  // --------------------------------------------------------------------------
  // Cell chain; the last cell is fed from the head so a shift rotates.
  // --------------------------------------------------------------------------
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam int NXT = (i == DEPTH - 1) ? 0 : i + 1;
    fqrm_cell #(
      .IW (IW),
      .IDX(i)
    ) u_cell (
      .clk_i (clk_i),
      .cmd_i (cmd),
      .tail_i(tail),
      .next_i(cell_data[NXT]),
      .data_o(cell_data[i])
    );
  end

  assign head     = cell_data[0];
  assign out_free = !out_valid_q || out_o.ready;
  assign in_i.ready = (st_q == ST_IDLE) && out_free;
  assign in_fire  = in_i.valid && in_i.ready;
  assign is_full  = (count_q == CW'(DEPTH));
  assign is_empty = (count_q == '0);
  assign match    = (head == key_q);

  always_comb begin
    st_d            = st_q;
    count_d         = count_q;
    remain_d        = remain_q;
    removed_d       = removed_q;
    key_d           = key_q;
    cmd.op          = fqrm_pkg::CMD_HOLD;
    cmd.keep        = 1'b0;
    cmd.wdata       = in_i.value;
    tail            = IW'(count_q - CW'(1));
    res_load        = 1'b0;
    res_data_d      = '0;
    res_removed_cnt = '0;
    res_status_d    = fqrm_pkg::STAT_OK;

    unique case (st_q)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (fqrm_pkg::action_e'(in_i.action))
            fqrm_pkg::ACT_ENQ: begin
              res_load = 1'b1;
              if (is_full) begin
                res_status_d = fqrm_pkg::STAT_FULL;
              end else begin
                cmd.op  = fqrm_pkg::CMD_APPEND;
                tail    = IW'(count_q);
                count_d = count_q + CW'(1);
              end
            end
            fqrm_pkg::ACT_DEQ: begin
              res_load = 1'b1;
              if (is_empty) begin
                res_status_d = fqrm_pkg::STAT_EMPTY;
              end else begin
                cmd.op     = fqrm_pkg::CMD_SHIFT;
                res_data_d = head;
                count_d    = count_q - CW'(1);
              end
            end
            fqrm_pkg::ACT_PEEK: begin
              res_load = 1'b1;
              if (is_empty) res_status_d = fqrm_pkg::STAT_EMPTY;
              else res_data_d = head;
            end
            fqrm_pkg::ACT_REMOVE: begin
              if (is_empty) begin
                res_load = 1'b1;
              end else begin
                st_d      = ST_REMOVE;
                key_d     = in_i.value;
                remain_d  = count_q;
                removed_d = '0;
              end
            end
            default: ;
          endcase
        end
      end
      ST_REMOVE: begin
        if (remain_q != '0) begin
          // Head leaves; a kept head re-enters at the tail of the live entries.
          cmd.op    = fqrm_pkg::CMD_SHIFT;
          cmd.keep  = !match;
          cmd.wdata = head;
          remain_d  = remain_q - CW'(1);
          if (match) begin
            count_d   = count_q - CW'(1);
            removed_d = removed_q + CW'(1);
          end
        end else if (out_free) begin
          res_load        = 1'b1;
          res_removed_cnt = removed_q;
          st_d            = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  assign occ_ext       = ExtW'(count_d);
  assign rem_ext       = ExtW'(res_removed_cnt);
  assign res_occ_d     = occ_ext[fqrm_pkg::FieldW-1:0];
  assign res_removed_d = rem_ext[fqrm_pkg::FieldW-1:0];
  assign res_empty_d   = (count_d == '0);

  always_comb begin
    out_valid_d = out_valid_q && !out_o.ready;
    if (res_load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      count_q     <= '0;
      remain_q    <= '0;
      removed_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      count_q     <= count_d;
      remain_q    <= remain_d;
      removed_q   <= removed_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    if (res_load) begin
      res_data_q    <= res_data_d;
      res_removed_q <= res_removed_d;
      res_occ_q     <= res_occ_d;
      res_empty_q   <= res_empty_d;
      res_status_q  <= res_status_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.data_out      = res_data_q;
  assign out_o.removed_count = res_removed_q;
  assign out_o.occupancy     = res_occ_q;
  assign out_o.is_empty      = res_empty_q;
  assign out_o.status        = res_status_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("occupancy above DEPTH");

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> (st_q == ST_IDLE))
    else $error("request accepted during remove walk");

  a_remain_le_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_REMOVE) |-> (remain_q <= count_q))
    else $error("remove walk longer than live entries");

  a_keep_holds_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_REMOVE && remain_q != '0 && !match) |=> (count_q == $past(count_q)))
    else $error("kept entry changed occupancy");

  a_no_result_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |-> out_free)
    else $error("result loaded over a pending transaction");

endmodule

@@ rtl/fqrm_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fqrm_cell
// One queue slot. Holds a word and takes its neighbor's word on a shift, but
// captures the broadcast word at the tail on an append or a keeping shift.
// ----------------------------------------------------------------------------
module fqrm_cell #(
  parameter int IW  = 4,
  parameter int IDX = 0
) (
  input  logic                            clk_i,
  input  fqrm_pkg::cell_cmd_t             cmd_i,
  input  logic [IW-1:0]                   tail_i,
  input  logic [fqrm_pkg::DataW-1:0]      next_i,
  output logic [fqrm_pkg::DataW-1:0]      data_o
);

  logic [fqrm_pkg::DataW-1:0] data_q, data_d;
  logic                       at_tail;

  assign at_tail = (tail_i == IW'(IDX));

  always_comb begin
    data_d = data_q;
    unique case (cmd_i.op)
      fqrm_pkg::CMD_APPEND: begin
        if (at_tail) data_d = cmd_i.wdata;
      end
      fqrm_pkg::CMD_SHIFT: begin
        if (at_tail && cmd_i.keep) data_d = cmd_i.wdata;
        else data_d = next_i;
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule
